@@ rtl/toi_pkg.sv @@
// ----------------------------------------------------------------------------
// toi_pkg
// Shared widths, outcome codes and sideband type for the circle time of
// impact pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package toi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIFF_W        = 33;
  localparam int AW            = 2 * DIFF_W;
  localparam int HW            = AW + 1;
  localparam int PW            = 2 * AW;
  localparam int LIMB_W        = DIFF_W;
  localparam int TIME_W        = 32;
  localparam int OUTC_W        = 3;

  localparam logic [OUTC_W-1:0] OUT_HIT     = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_STILL   = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_OVERLAP = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_NO_ROOT = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_PAST    = 3'd4;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [AW-1:0]     a;
    logic [AW-1:0]     habs;
  } toi_side_t;

  function automatic logic [DIFF_W-1:0] mag_f(input logic [DIFF_W-1:0] v);
    mag_f = v[DIFF_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [HW-1:0] signed_f(input logic [AW-1:0] p, input logic neg);
    logic [HW-1:0] e;
    e = {1'b0, p};
    signed_f = neg ? (~e + 1'b1) : e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/toi_front.sv @@
// ----------------------------------------------------------------------------
// toi_front
// Eight-stage front end: relative motion, quadratic coefficients A, H, C and
// the discriminant H*H - A*C, with early outcome classification.
// ----------------------------------------------------------------------------
`default_nettype none

module toi_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic signed [31:0]         first_x,
  input  logic signed [31:0]         first_y,
  input  logic signed [31:0]         first_vel_x,
  input  logic signed [31:0]         first_vel_y,
  input  logic        [30:0]         first_radius,
  input  logic signed [31:0]         second_x,
  input  logic signed [31:0]         second_y,
  input  logic signed [31:0]         second_vel_x,
  input  logic signed [31:0]         second_vel_y,
  input  logic        [30:0]         second_radius,
  output logic                       out_valid,
  output toi_pkg::toi_side_t         out_side,
  output logic [toi_pkg::PW-1:0]     out_disc
);
  import toi_pkg::*;

  logic [7:0] vld;

  logic [DIFF_W-1:0] dx1, dy1, dvx1, dvy1;
  logic [31:0]       rsum1;

  logic [DIFF_W-1:0] ax2, ay2, avx2, avy2;
  logic              n1_2, n2_2, still2;
  logic [31:0]       rsum2;

  logic [AW-1:0]     vxx3, vyy3, xx3, yy3, hx3, hy3;
  logic [63:0]       rr3;
  logic              n1_3, n2_3, still3;

  logic [AW-1:0]     a4, cp4;
  logic [HW-1:0]     hs4, hs4_neg;
  logic [63:0]       rr4;
  logic              still4;

  logic [AW-1:0]     a5, c5, habs5;
  logic              still5, ovl5, hpos5;

  logic [AW-1:0]     a6, habs6;
  logic [AW-1:0]     hll6, hlh6, hhh6, acll6, aclh6, achl6, achh6;
  logic              still6, ovl6, hpos6;

  logic [AW:0]       cross6;
  logic [AW-1:0]     a7, habs7;
  logic [PW-1:0]     p7, q7;
  logic              still7, ovl7, hpos7;

  logic [OUTC_W-1:0] outc7;

  assign hs4_neg = ~hs4 + 1'b1;
  assign cross6  = {1'b0, aclh6} + {1'b0, achl6};

  always_comb begin
    if (still7) begin
      outc7 = OUT_STILL;
    end else if (ovl7) begin
      outc7 = OUT_OVERLAP;
    end else if (p7 < q7) begin
      outc7 = OUT_NO_ROOT;
    end else if (hpos7) begin
      outc7 = OUT_PAST;
    end else begin
      outc7 = OUT_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1   <= {second_x[31], second_x} - {first_x[31], first_x};
      dy1   <= {second_y[31], second_y} - {first_y[31], first_y};
      dvx1  <= {second_vel_x[31], second_vel_x} - {first_vel_x[31], first_vel_x};
      dvy1  <= {second_vel_y[31], second_vel_y} - {first_vel_y[31], first_vel_y};
      rsum1 <= {1'b0, first_radius} + {1'b0, second_radius};

      ax2    <= mag_f(dx1);
      ay2    <= mag_f(dy1);
      avx2   <= mag_f(dvx1);
      avy2   <= mag_f(dvy1);
      n1_2   <= dvx1[DIFF_W-1] ^ dx1[DIFF_W-1];
      n2_2   <= dvy1[DIFF_W-1] ^ dy1[DIFF_W-1];
      still2 <= (dvx1 == '0) && (dvy1 == '0);
      rsum2  <= rsum1;

      vxx3   <= avx2 * avx2;
      vyy3   <= avy2 * avy2;
      xx3    <= ax2 * ax2;
      yy3    <= ay2 * ay2;
      hx3    <= avx2 * ax2;
      hy3    <= avy2 * ay2;
      rr3    <= rsum2 * rsum2;
      n1_3   <= n1_2;
      n2_3   <= n2_2;
      still3 <= still2;

      a4     <= vxx3 + vyy3;
      cp4    <= xx3 + yy3;
      hs4    <= signed_f(hx3, n1_3) + signed_f(hy3, n2_3);
      rr4    <= rr3;
      still4 <= still3;

      a5     <= a4;
      ovl5   <= cp4 < {2'b00, rr4};
      c5     <= cp4 - {2'b00, rr4};
      habs5  <= hs4[HW-1] ? hs4_neg[AW-1:0] : hs4[AW-1:0];
      hpos5  <= !hs4[HW-1] && (hs4 != '0);
      still5 <= still4;

      hll6   <= habs5[LIMB_W-1:0] * habs5[LIMB_W-1:0];
      hlh6   <= habs5[LIMB_W-1:0] * habs5[AW-1:LIMB_W];
      hhh6   <= habs5[AW-1:LIMB_W] * habs5[AW-1:LIMB_W];
      acll6  <= a5[LIMB_W-1:0] * c5[LIMB_W-1:0];
      aclh6  <= a5[LIMB_W-1:0] * c5[AW-1:LIMB_W];
      achl6  <= a5[AW-1:LIMB_W] * c5[LIMB_W-1:0];
      achh6  <= a5[AW-1:LIMB_W] * c5[AW-1:LIMB_W];
      a6     <= a5;
      habs6  <= habs5;
      still6 <= still5;
      ovl6   <= ovl5;
      hpos6  <= hpos5;

      p7     <= {hhh6, {AW{1'b0}}} + {{(LIMB_W-1){1'b0}}, hlh6, {(LIMB_W+1){1'b0}}}
                + {{AW{1'b0}}, hll6};
      q7     <= {achh6, {AW{1'b0}}} + {{(LIMB_W-1){1'b0}}, cross6, {LIMB_W{1'b0}}}
                + {{AW{1'b0}}, acll6};
      a7     <= a6;
      habs7  <= habs6;
      still7 <= still6;
      ovl7   <= ovl6;
      hpos7  <= hpos6;

      out_disc         <= p7 - q7;
      out_side.outcome <= outc7;
      out_side.a       <= a7;
      out_side.habs    <= habs7;
    end
  end

  assign out_valid = vld[7];

endmodule

`default_nettype wire

@@ rtl/toi_sqrt.sv @@
// ----------------------------------------------------------------------------
// toi_sqrt
// Pipelined restoring square root of disc * 2^(2*FRAC_BITS), one root bit
// per stage, with a nonzero-remainder flag for rounding up.
// ----------------------------------------------------------------------------
`default_nettype none

module toi_sqrt #(
  parameter int FRAC_BITS = toi_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  toi_pkg::toi_side_t                    in_side,
  input  logic [toi_pkg::PW-1:0]                in_disc,
  output logic                                  out_valid,
  output toi_pkg::toi_side_t                    out_side,
  output logic [toi_pkg::PW/2+FRAC_BITS-1:0]    out_root,
  output logic                                  out_rem_nz
);
  import toi_pkg::*;

  localparam int XW   = PW + 2 * FRAC_BITS;
  localparam int RW   = XW / 2;
  localparam int REMW = RW + 2;

  logic [RW-1:0]   vld;
  logic [REMW-1:0] rem      [RW];
  logic [RW-1:0]   root     [RW];
  logic [XW-1:0]   rad      [RW];
  toi_side_t       side     [RW];

  logic [REMW-1:0] rem_in   [RW];
  logic [RW-1:0]   root_in  [RW];
  logic [XW-1:0]   rad_in   [RW];
  logic [REMW+1:0] cat      [RW];
  logic [REMW+1:0] trial    [RW];
  logic [REMW+1:0] diff     [RW];
  logic            ge       [RW];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = {in_disc, {(2*FRAC_BITS){1'b0}}};
    for (int k = 1; k < RW; k++) begin
      rem_in[k]  = rem[k-1];
      root_in[k] = root[k-1];
      rad_in[k]  = rad[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      cat[k]   = {rem_in[k], rad_in[k][XW-1 -: 2]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      ge[k]    = cat[k] >= trial[k];
      diff[k]  = cat[k] - trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= in_side;
      for (int k = 1; k < RW; k++) begin
        side[k] <= side[k-1];
      end
      for (int k = 0; k < RW; k++) begin
        rem[k]  <= ge[k] ? diff[k][REMW-1:0] : cat[k][REMW-1:0];
        root[k] <= {root_in[k][RW-2:0], ge[k]};
        rad[k]  <= rad_in[k] << 2;
      end
    end
  end

  assign out_valid  = vld[RW-1];
  assign out_side   = side[RW-1];
  assign out_root   = root[RW-1];
  assign out_rem_nz = rem[RW-1] != '0;

endmodule

`default_nettype wire

@@ rtl/toi_div.sv @@
// ----------------------------------------------------------------------------
// toi_div
// Numerator 2^F*|H| - ceil(sqrt), pipelined restoring divide by A with one
// quotient bit per stage, saturation and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module toi_div #(
  parameter int FRAC_BITS = toi_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  toi_pkg::toi_side_t                    in_side,
  input  logic [toi_pkg::PW/2+FRAC_BITS-1:0]    in_root,
  input  logic                                  in_rem_nz,
  output logic                                  out_valid,
  output logic                                  hit,
  output logic [toi_pkg::TIME_W-1:0]            contact_time,
  output logic [toi_pkg::OUTC_W-1:0]            outcome
);
  import toi_pkg::*;

  localparam int NW = AW + FRAC_BITS;
  localparam int DW = AW + TIME_W;
  localparam int QN = TIME_W;

  logic              n_v;
  logic [NW-1:0]     n_q;
  toi_side_t         n_side;

  logic [QN-1:0]     vld;
  logic [DW-1:0]     drem    [QN];
  logic [QN-1:0]     quo     [QN];
  logic              sat     [QN];
  toi_side_t         side    [QN];

  logic [DW-1:0]     rem_in  [QN];
  logic [QN-1:0]     quo_in  [QN];
  logic              sat_in  [QN];
  logic [DW-1:0]     dvs     [QN];
  logic              ge      [QN];

  logic              last_hit;

  always_comb begin
    rem_in[0] = DW'(n_q);
    quo_in[0] = '0;
    sat_in[0] = DW'(n_q) >= {n_side.a, {QN{1'b0}}};
    for (int k = 1; k < QN; k++) begin
      rem_in[k] = drem[k-1];
      quo_in[k] = quo[k-1];
      sat_in[k] = sat[k-1];
    end
    for (int k = 0; k < QN; k++) begin
      dvs[k] = DW'(n_side.a) << (QN - 1 - k);
      ge[k]  = rem_in[k] >= dvs[k];
    end
    for (int k = 1; k < QN; k++) begin
      dvs[k] = DW'(side[k-1].a) << (QN - 1 - k);
      ge[k]  = rem_in[k] >= dvs[k];
    end
  end

  assign last_hit = side[QN-1].outcome == OUT_HIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v       <= 1'b0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      n_v       <= in_valid;
      vld       <= {vld[QN-2:0], n_v};
      out_valid <= vld[QN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_q    <= {in_side.habs, {FRAC_BITS{1'b0}}} - in_root - NW'(in_rem_nz);
      n_side <= in_side;

      side[0] <= n_side;
      for (int k = 1; k < QN; k++) begin
        side[k] <= side[k-1];
      end
      for (int k = 0; k < QN; k++) begin
        drem[k] <= ge[k] ? (rem_in[k] - dvs[k]) : rem_in[k];
        quo[k]  <= {quo_in[k][QN-2:0], ge[k]};
        sat[k]  <= sat_in[k];
      end

      hit          <= last_hit;
      outcome      <= side[QN-1].outcome;
      contact_time <= !last_hit    ? '0 :
                      sat[QN-1]    ? '1 : quo[QN-1];
    end
  end

endmodule

`default_nettype wire

@@ rtl/circle_time_of_impact_top.sv @@
// Throughput: one transaction per cycle; a stalled output holds every stage.
// Depth is set by the square root, one stage per root bit (66 + FRAC_BITS),
// and the divider, one stage per contact_time bit.
// Reset clears the valid bits of all stages; data registers are not reset.
// ----------------------------------------------------------------------------
// circle_time_of_impact_top
// Earliest contact time of two moving circles from signed inputs, as unsigned fixed point, pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_time_of_impact_top #(
  parameter int FRAC_BITS = toi_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [31:0]               first_x,
  input  logic signed [31:0]               first_y,
  input  logic signed [31:0]               first_vel_x,
  input  logic signed [31:0]               first_vel_y,
  input  logic        [30:0]               first_radius,
  input  logic signed [31:0]               second_x,
  input  logic signed [31:0]               second_y,
  input  logic signed [31:0]               second_vel_x,
  input  logic signed [31:0]               second_vel_y,
  input  logic        [30:0]               second_radius,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic [toi_pkg::TIME_W-1:0]       contact_time,
  output logic [toi_pkg::OUTC_W-1:0]       outcome
);
  import toi_pkg::*;

  localparam int RW = PW / 2 + FRAC_BITS;

  logic          adv;
  logic          fr_valid;
  toi_side_t     fr_side;
  logic [PW-1:0] fr_disc;
  logic          sq_valid;
  toi_side_t     sq_side;
  logic [RW-1:0] sq_root;
  logic          sq_rem_nz;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  toi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (in_valid),
    .first_x       (first_x),
    .first_y       (first_y),
    .first_vel_x   (first_vel_x),
    .first_vel_y   (first_vel_y),
    .first_radius  (first_radius),
    .second_x      (second_x),
    .second_y      (second_y),
    .second_vel_x  (second_vel_x),
    .second_vel_y  (second_vel_y),
    .second_radius (second_radius),
    .out_valid     (fr_valid),
    .out_side      (fr_side),
    .out_disc      (fr_disc)
  );

  toi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (fr_valid),
    .in_side    (fr_side),
    .in_disc    (fr_disc),
    .out_valid  (sq_valid),
    .out_side   (sq_side),
    .out_root   (sq_root),
    .out_rem_nz (sq_rem_nz)
  );

  toi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (sq_valid),
    .in_side      (sq_side),
    .in_root      (sq_root),
    .in_rem_nz    (sq_rem_nz),
    .out_valid    (out_valid),
    .hit          (hit),
    .contact_time (contact_time),
    .outcome      (outcome)
  );

endmodule

`default_nettype wire

@@ rtl/toi_checker.sv @@
// ----------------------------------------------------------------------------
// toi_checker
// Port-level checks on the circle time of impact block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module toi_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic [toi_pkg::TIME_W-1:0]  contact_time,
  input logic [toi_pkg::OUTC_W-1:0]  outcome
);
  import toi_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(contact_time)
                                && $stable(outcome))
    else $error("result changed while stalled");

  a_stall_intake: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit == (outcome == OUT_HIT))
    else $error("hit flag disagrees with outcome");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> contact_time == '0)
    else $error("nonzero time without hit");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind circle_time_of_impact_top toi_checker u_toi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .hit          (hit),
  .contact_time (contact_time),
  .outcome      (outcome)
);

`default_nettype wire
